FILE: rtl/core/cfac_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame CRC block.
package cfac_pkg;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic CMD_DECODE = 1'b1;
   localparam logic SCHEME_CRC = 1'b1;

   localparam logic [1:0] SEEN_PAIR = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   // How the back end expands one queued work entry into result beats.
   typedef enum logic [1:0] {
      KIND_BYTE         = 2'd0,   // one byte
      KIND_BYTE_CRC     = 2'd1,   // byte, CRC high, CRC low
      KIND_VERDICT      = 2'd2,   // verdict only
      KIND_BYTE_VERDICT = 2'd3    // byte, then verdict
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] crc;
      logic        eof;
      status_type  status;
   } work_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       eof;
      status_type status;
   } beat_type;

   function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/cfac_front.sv
// Front end: takes input beats, runs the CRC state and queues work entries.
module cfac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               accept,
   input  logic               command,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output logic               work_push,
   output cfac_pkg::work_type work
);
   import cfac_pkg::*;

   logic        scheme_ff, scheme_in;
   logic [15:0] crc_ff, crc_in;
   logic [1:0]  seen_ff, seen_in;
   logic [7:0]  older_ff, older_in;
   logic [7:0]  newer_ff, newer_in;
   logic [7:0]  feed_byte;
   logic [15:0] crc_fed;
   logic        have_pair;
   logic        clear_frame;

   assign feed_byte = (command == CMD_DECODE) ? older_ff : data_byte;
   assign crc_fed   = crc_feed_byte(crc_ff, feed_byte);
   assign have_pair = (seen_ff == SEEN_PAIR);

   always_comb begin
      scheme_in   = csr_wr_en ? csr_wr_data : scheme_ff;
      crc_in      = crc_ff;
      seen_in     = seen_ff;
      older_in    = older_ff;
      newer_in    = newer_ff;
      clear_frame = 1'b0;
      work_push   = 1'b0;
      work.kind   = KIND_BYTE;
      work.data   = data_byte;
      work.crc    = crc_fed;
      work.eof    = 1'b0;
      work.status = STATUS_OK;
      if (accept) begin
         if (scheme_ff != SCHEME_CRC) begin
            // passthrough: forward and drop any partial frame
            work_push   = 1'b1;
            work.eof    = last_byte;
            clear_frame = 1'b1;
         end else if (command != CMD_DECODE) begin
            crc_in      = crc_fed;
            work_push   = 1'b1;
            work.kind   = last_byte ? KIND_BYTE_CRC : KIND_BYTE;
            clear_frame = last_byte;
         end else begin
            // decode: hold the newest two bytes, release the older one
            if (have_pair) begin
               crc_in = crc_fed;
            end
            seen_in   = have_pair ? SEEN_PAIR : seen_ff + 2'd1;
            older_in  = newer_ff;
            newer_in  = data_byte;
            work.data = older_ff;
            if (seen_in != SEEN_PAIR) begin
               work.status = STATUS_SHORT;
            end else if ({newer_ff, data_byte} == crc_in) begin
               work.status = STATUS_OK;
            end else begin
               work.status = STATUS_MISMATCH;
            end
            if (last_byte) begin
               work_push   = 1'b1;
               work.kind   = have_pair ? KIND_BYTE_VERDICT : KIND_VERDICT;
               clear_frame = 1'b1;
            end else begin
               work_push = have_pair;
            end
         end
         if (clear_frame) begin
            crc_in   = CRC_INIT;
            seen_in  = 2'd0;
            older_in = 8'h00;
            newer_in = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= 1'b0;
         crc_ff    <= CRC_INIT;
         seen_ff   <= 2'd0;
         older_ff  <= 8'h00;
         newer_ff  <= 8'h00;
      end else begin
         scheme_ff <= scheme_in;
         crc_ff    <= crc_in;
         seen_ff   <= seen_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
      end
   end

endmodule

FILE: rtl/core/cfac_queue.sv
// Work queue between the front and back ends.
module cfac_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  cfac_pkg::work_type wr_data,
   output logic               q_full,
   input  logic               rd_en,
   output cfac_pkg::work_type rd_data,
   output logic               q_empty
);
   import cfac_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type               mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_wr, do_rd;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/cfac_back.sv
// Back end: expands work entries into result beats behind an output register.
module cfac_back (
   input  logic               clock,
   input  logic               reset,
   input  cfac_pkg::work_type head,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic               pop,
   output logic               empty,
   output cfac_pkg::beat_type beat
);
   import cfac_pkg::*;

   logic [1:0] beat_idx_ff, beat_idx_in;
   logic       out_valid_ff, out_valid_in;
   beat_type   beat_ff, beat_in;
   beat_type   next_beat;
   logic       last_beat;
   logic       load;

   assign load = !q_empty && (!out_valid_ff || pop);

   always_comb begin
      next_beat.data   = head.data;
      next_beat.valid  = 1'b1;
      next_beat.eof    = 1'b0;
      next_beat.status = STATUS_OK;
      case (beat_idx_ff)
         2'd0: begin
            if (head.kind == KIND_VERDICT) begin
               next_beat.data   = 8'h00;
               next_beat.valid  = 1'b0;
               next_beat.eof    = 1'b1;
               next_beat.status = head.status;
            end else if (head.kind == KIND_BYTE) begin
               next_beat.eof = head.eof;
            end
         end
         2'd1: begin
            if (head.kind == KIND_BYTE_VERDICT) begin
               next_beat.data   = 8'h00;
               next_beat.valid  = 1'b0;
               next_beat.eof    = 1'b1;
               next_beat.status = head.status;
            end else begin
               next_beat.data = head.crc[15:8];
            end
         end
         default: begin
            next_beat.data = head.crc[7:0];
            next_beat.eof  = 1'b1;
         end
      endcase
   end

   always_comb begin
      case (head.kind)
         KIND_BYTE_CRC:     last_beat = (beat_idx_ff == 2'd2);
         KIND_BYTE_VERDICT: last_beat = (beat_idx_ff == 2'd1);
         default:           last_beat = 1'b1;
      endcase
   end

   always_comb begin
      q_pop        = load && last_beat;
      beat_idx_in  = beat_idx_ff;
      out_valid_in = out_valid_ff;
      beat_in      = beat_ff;
      if (load) begin
         beat_idx_in  = last_beat ? 2'd0 : beat_idx_ff + 2'd1;
         out_valid_in = 1'b1;
         beat_in      = next_beat;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_idx_ff  <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_idx_ff  <= beat_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign empty = !out_valid_ff;
   assign beat  = beat_ff;

endmodule

FILE: rtl/core/crc16_frame_append_check.sv
// Top level of the frame CRC-16 appender and checker.
//
// Frames come in one byte per beat on the req_ side (push/full) and results leave on the
// rsp_ side (empty/pop). With csr_wr_data = 0 every byte passes through unchanged. With 1
// the block runs CRC-16 (poly 0x1021, init 0xFFFF, no reflection, no final xor): an encode
// byte passes through and the last one is followed by the CRC, high byte first; a decode
// frame has its last two bytes held back as the received CRC, data bytes leave two
// positions late, and one verdict beat (byte_valid low, end_of_frame high) closes the
// frame with status ok, mismatch or too short. The payload goes out before the verdict,
// so drop the frame on a bad status. Rate: one input byte per cycle, back to back, while
// each byte makes at most one result beat and pop stays high. An encode last byte makes
// three result beats and a decode last byte up to two; while pop stays high the back end
// puts out one result beat per cycle, so the QUEUE_DEPTH-entry work queue takes up the
// extra beats and full rises, holding the input, once the queue fills. The first result
// beat of an accepted byte passes through the work queue and the output register before
// it reaches the rsp_ ports. Write csr only while the block is idle.
module crc16_frame_append_check #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   // input beats
   input  logic       push,
   output logic       full,
   input  logic       req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   // result beats
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_frame,
   output logic [1:0] rsp_status
);
   import cfac_pkg::*;

   logic     accept;
   logic     work_push;
   work_type work;
   work_type head;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   beat_type beat;

   // take a beat whenever the queue has room
   assign full   = q_full;
   assign accept = push && !q_full;

   cfac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .command     (req_command),
      .data_byte   (req_data_byte),
      .last_byte   (req_last_byte),
      .work_push   (work_push),
      .work        (work)
   );

   cfac_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (work_push),
      .wr_data (work),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (head),
      .q_empty (q_empty)
   );

   cfac_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .beat    (beat)
   );

   assign rsp_out_byte     = beat.data;
   assign rsp_byte_valid   = beat.valid;
   assign rsp_end_of_frame = beat.eof;
   assign rsp_status       = beat.status;

   // a beat without a byte is always a verdict
   a_verdict_closes_frame : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_byte_valid) |-> rsp_end_of_frame)
      else $error("byte-less result beat without end_of_frame");

   // a bad status only rides on a verdict beat
   a_status_on_verdict : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != STATUS_OK) |-> (rsp_end_of_frame && !rsp_byte_valid))
      else $error("nonzero status outside a verdict beat");

   // reset leaves both sides drained
   a_reset_drains : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not drained after reset");

endmodule
